[rtl/ptls_pkg.sv]
// ----------------------------------------------------------------------------
// ptls_pkg
// Types and constants shared by the pedestrian traffic light sequencer.
// ----------------------------------------------------------------------------
package ptls_pkg;

  localparam int TICKS_PER_SECOND = 4;
  localparam int TPS_LOG2         = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 0;

  localparam int PHASE_SEC_W  = 6;
  localparam int HALF_TICKS_W = 8;
  localparam int BLINK_CYC_W  = 4;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 8;
  localparam int PHASE_CODE_W = 4;

  // tick counter holds phase_seconds * TICKS_PER_SECOND and a blink half-period
  localparam int STEADY_W = PHASE_SEC_W + TPS_LOG2;
  localparam int CNT_W    = (STEADY_W > HALF_TICKS_W) ? STEADY_W : HALF_TICKS_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_SECONDS     = 2'd0,
    CFG_HALF_SECOND_TICKS = 2'd1,
    CFG_BLINK_CYCLES      = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [PHASE_SEC_W-1:0]  phase_seconds;
    logic [HALF_TICKS_W-1:0] half_second_ticks;
    logic [BLINK_CYC_W-1:0]  blink_cycles;
  } cfg_t;

  typedef struct packed {
    logic tick;
    logic button_press;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

  typedef enum logic [9:0] {
    PH_GREEN      = 10'b00_0000_0001,
    PH_YELLOW_A   = 10'b00_0000_0010,
    PH_RED        = 10'b00_0000_0100,
    PH_YELLOW_B   = 10'b00_0000_1000,
    PH_WARN_GREEN = 10'b00_0001_0000,
    PH_WARN_BLINK = 10'b00_0010_0000,
    PH_PRE_WALK   = 10'b00_0100_0000,
    PH_WALK       = 10'b00_1000_0000,
    PH_WALK_BLINK = 10'b01_0000_0000,
    PH_EXIT       = 10'b10_0000_0000
  } phase_t;

  typedef enum logic [1:0] {
    COL_GREEN  = 2'd0,
    COL_YELLOW = 2'd1,
    COL_RED    = 2'd2
  } colour_t;

endpackage

[rtl/ptls_cfg.sv]
// ----------------------------------------------------------------------------
// ptls_cfg
// Configuration register file for phase and blink timing.
// ----------------------------------------------------------------------------
module ptls_cfg import ptls_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_PHASE_SECONDS:     cfg_nxt.phase_seconds     = cfg_data[PHASE_SEC_W-1:0];
        CFG_HALF_SECOND_TICKS: cfg_nxt.half_second_ticks = cfg_data[HALF_TICKS_W-1:0];
        CFG_BLINK_CYCLES:      cfg_nxt.blink_cycles      = cfg_data[BLINK_CYC_W-1:0];
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.phase_seconds     <= PHASE_SEC_W'(5);
      cfg_r.half_second_ticks <= HALF_TICKS_W'(2);
      cfg_r.blink_cycles      <= BLINK_CYC_W'(5);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[rtl/ptls_in_stage.sv]
// ----------------------------------------------------------------------------
// ptls_in_stage
// Input register for tick and button items.
// ----------------------------------------------------------------------------
module ptls_in_stage import ptls_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_stall,
  input  logic   in_tick,
  input  logic   in_button_press,
  input  logic   take,
  output stage_t stage
);

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  accept;

  assign in_stall = valid_r & ~take;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.tick         <= in_tick;
      item_r.button_press <= in_button_press;
    end
  end

  assign stage.valid = valid_r;
  assign stage.item  = item_r;

endmodule

[rtl/ptls_seq.sv]
// ----------------------------------------------------------------------------
// ptls_seq
// Phase state machine, timing counters and registered lamp result.
// ----------------------------------------------------------------------------
module ptls_seq import ptls_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cfg_t                    cfg,
  input  stage_t                  stage,
  output logic                    take,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_car_green,
  output logic                    out_car_yellow,
  output logic                    out_car_red,
  output logic                    out_walk_green,
  output logic                    out_walk_yellow,
  output logic                    out_walk_red,
  output logic [PHASE_CODE_W-1:0] out_phase_code,
  output logic                    out_pedestrian_active
);

  phase_t                 phase_r, phase_nxt;
  logic [CNT_W-1:0]       tick_count_r, tick_count_nxt;
  logic [BLINK_CYC_W-1:0] blink_count_r, blink_count_nxt;
  logic                   blink_on_r, blink_on_nxt;
  colour_t                colour_r, colour_nxt;
  logic                   out_valid_r, out_valid_nxt;

  logic                   cg_r, cy_r, cr_r, wg_r, wy_r, wr_r;
  logic [PHASE_CODE_W-1:0] code_r;
  logic                   ped_r;

  logic                   enter;
  phase_t                 enter_ph;
  logic [CNT_W:0]         cnt_inc;
  logic [CNT_W:0]         half_lim;
  logic [CNT_W:0]         steady_lim;
  logic [BLINK_CYC_W-1:0] cycles_lim;
  logic [BLINK_CYC_W-1:0] bc_inc;
  logic                   cg, cy, cr, wg, wy, wr;

  function automatic logic is_blink(phase_t p);
    return (p == PH_YELLOW_A) || (p == PH_YELLOW_B) || (p == PH_WARN_BLINK) ||
           (p == PH_PRE_WALK) || (p == PH_WALK_BLINK);
  endfunction

  function automatic logic is_ped(phase_t p);
    return !((p == PH_GREEN) || (p == PH_YELLOW_A) || (p == PH_RED) || (p == PH_YELLOW_B));
  endfunction

  function automatic phase_t next_phase(phase_t p);
    phase_t n;
    case (p)
      PH_GREEN:      n = PH_YELLOW_A;
      PH_YELLOW_A:   n = PH_RED;
      PH_RED:        n = PH_YELLOW_B;
      PH_WARN_GREEN: n = PH_PRE_WALK;
      PH_WARN_BLINK: n = PH_PRE_WALK;
      PH_PRE_WALK:   n = PH_WALK;
      PH_WALK:       n = PH_WALK_BLINK;
      PH_WALK_BLINK: n = PH_EXIT;
      default:       n = PH_GREEN;
    endcase
    return n;
  endfunction

  function automatic logic [PHASE_CODE_W-1:0] phase_code(phase_t p);
    logic [PHASE_CODE_W-1:0] c;
    case (p)
      PH_GREEN:      c = PHASE_CODE_W'(0);
      PH_YELLOW_A:   c = PHASE_CODE_W'(1);
      PH_RED:        c = PHASE_CODE_W'(2);
      PH_YELLOW_B:   c = PHASE_CODE_W'(3);
      PH_WARN_GREEN: c = PHASE_CODE_W'(4);
      PH_WARN_BLINK: c = PHASE_CODE_W'(5);
      PH_PRE_WALK:   c = PHASE_CODE_W'(6);
      PH_WALK:       c = PHASE_CODE_W'(7);
      PH_WALK_BLINK: c = PHASE_CODE_W'(8);
      PH_EXIT:       c = PHASE_CODE_W'(9);
      default:       c = PHASE_CODE_W'(0);
    endcase
    return c;
  endfunction

  assign take = stage.valid & (~out_valid_r | ~out_stall);

  // zero register values act as one
  assign half_lim   = (cfg.half_second_ticks == '0) ? (CNT_W+1)'(1)
                                                    : (CNT_W+1)'(cfg.half_second_ticks);
  assign steady_lim = ((cfg.phase_seconds == '0) ? (CNT_W+1)'(1)
                                                 : (CNT_W+1)'(cfg.phase_seconds))
                      * (CNT_W+1)'(TICKS_PER_SECOND);
  assign cycles_lim = (cfg.blink_cycles == '0) ? BLINK_CYC_W'(1) : cfg.blink_cycles;
  assign cnt_inc    = (CNT_W+1)'(tick_count_r) + (CNT_W+1)'(1);
  assign bc_inc     = blink_count_r + BLINK_CYC_W'(1);

  always_comb begin
    phase_nxt       = phase_r;
    tick_count_nxt  = tick_count_r;
    blink_count_nxt = blink_count_r;
    blink_on_nxt    = blink_on_r;
    colour_nxt      = colour_r;
    enter           = 1'b0;
    enter_ph        = phase_r;

    if (take) begin
      if (stage.item.button_press && !is_ped(phase_r)) begin
        enter = 1'b1;
        case (colour_r)
          COL_RED:    enter_ph = PH_WALK;
          COL_YELLOW: enter_ph = PH_WARN_BLINK;
          default:    enter_ph = PH_WARN_GREEN;
        endcase
      end else if (stage.item.tick) begin
        if (is_blink(phase_r)) begin
          if (cnt_inc >= half_lim) begin
            tick_count_nxt = '0;
            if (blink_on_r) begin
              blink_on_nxt = 1'b0;
            end else begin
              blink_on_nxt    = 1'b1;
              blink_count_nxt = bc_inc;
              if (bc_inc >= cycles_lim) begin
                enter    = 1'b1;
                enter_ph = next_phase(phase_r);
              end
            end
          end else begin
            tick_count_nxt = cnt_inc[CNT_W-1:0];
          end
        end else begin
          if (cnt_inc >= steady_lim) begin
            enter    = 1'b1;
            enter_ph = next_phase(phase_r);
          end else begin
            tick_count_nxt = cnt_inc[CNT_W-1:0];
          end
        end
      end
    end

    if (enter) begin
      phase_nxt       = enter_ph;
      tick_count_nxt  = '0;
      blink_count_nxt = '0;
      blink_on_nxt    = 1'b1;
      case (enter_ph)
        PH_GREEN:    colour_nxt = COL_GREEN;
        PH_YELLOW_A: colour_nxt = COL_YELLOW;
        PH_YELLOW_B: colour_nxt = COL_YELLOW;
        PH_RED:      colour_nxt = COL_RED;
        default:     colour_nxt = colour_r;
      endcase
    end
  end

  // lamps as they stand after the item
  always_comb begin
    cg = 1'b0;
    cy = 1'b0;
    cr = 1'b0;
    wg = 1'b0;
    wy = 1'b0;
    wr = 1'b0;
    case (phase_nxt)
      PH_GREEN:      cg = 1'b1;
      PH_YELLOW_A:   cy = blink_on_nxt;
      PH_RED:        cr = 1'b1;
      PH_YELLOW_B:   cy = blink_on_nxt;
      PH_WARN_GREEN: begin
        cg = 1'b1;
        wr = 1'b1;
      end
      PH_WARN_BLINK: begin
        cy = blink_on_nxt;
        wr = 1'b1;
      end
      PH_PRE_WALK: begin
        cy = blink_on_nxt;
        wy = blink_on_nxt;
      end
      PH_WALK: begin
        cr = 1'b1;
        wg = 1'b1;
      end
      PH_WALK_BLINK: begin
        cy = blink_on_nxt;
        wy = blink_on_nxt;
        wg = 1'b1;
      end
      PH_EXIT: begin
        cg = 1'b1;
        wr = 1'b1;
      end
      default: cg = 1'b0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r & out_stall;
    if (take) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_GREEN;
      tick_count_r  <= '0;
      blink_count_r <= '0;
      blink_on_r    <= 1'b1;
      colour_r      <= COL_GREEN;
      out_valid_r   <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      tick_count_r  <= tick_count_nxt;
      blink_count_r <= blink_count_nxt;
      blink_on_r    <= blink_on_nxt;
      colour_r      <= colour_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cg_r   <= cg;
      cy_r   <= cy;
      cr_r   <= cr;
      wg_r   <= wg;
      wy_r   <= wy;
      wr_r   <= wr;
      code_r <= phase_code(phase_nxt);
      ped_r  <= is_ped(phase_nxt);
    end
  end

  assign out_valid             = out_valid_r;
  assign out_car_green         = cg_r;
  assign out_car_yellow        = cy_r;
  assign out_car_red           = cr_r;
  assign out_walk_green        = wg_r;
  assign out_walk_yellow       = wy_r;
  assign out_walk_red          = wr_r;
  assign out_phase_code        = code_r;
  assign out_pedestrian_active = ped_r;

  a_ped_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (ped_r == (code_r >= PHASE_CODE_W'(4))))
    else $error("pedestrian flag disagrees with phase code");

  a_one_car_lamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot0({cg_r, cy_r, cr_r}))
    else $error("more than one car lamp lit");

  a_press_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    (take && stage.item.button_press && !stage.item.tick && is_ped(phase_r))
    |=> (phase_r == $past(phase_r)))
    else $error("press changed phase during pedestrian sequence");

  a_blink_count: assert property (@(posedge clk) disable iff (!rst_n)
    !is_blink(phase_r) |-> (blink_count_r == '0 && blink_on_r))
    else $error("blink state moved in a steady phase");

  a_take_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !take)
    else $error("result overwritten while stalled");

endmodule

[rtl/pedestrian_traffic_light_sequencer.sv]
// ----------------------------------------------------------------------------
// pedestrian_traffic_light_sequencer
// Car and pedestrian lamp sequencer driven by timebase ticks and button edges.
// ----------------------------------------------------------------------------
// Usage:
//   in_ channel: one item per tick period carrying in_tick and
//   in_button_press; an item is taken when in_valid is high and in_stall low.
//   out_ channel: one result item per input item with the six lamps, the
//   phase code and the pedestrian flag as they stand after that item.
//   cfg_ channel: index 0 phase_seconds, 1 half_second_ticks, 2 blink_cycles;
//   cfg_ready is always high, write only while no item is in flight.
//   An accepted item loads the input register; the state update then fills
//   the result register when the item is taken, which waits while a held
//   result is stalled. Throughput is one item per cycle while out_stall
//   is low, set by the state update.
//   Reset (rst_n low, synchronous) returns to normal car green with default
//   timing. When out_stall is high the result holds, the held input item
//   waits, and in_stall rises once the input register is full.
// ----------------------------------------------------------------------------
module pedestrian_traffic_light_sequencer import ptls_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_tick,
  input  logic                    in_button_press,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_car_green,
  output logic                    out_car_yellow,
  output logic                    out_car_red,
  output logic                    out_walk_green,
  output logic                    out_walk_yellow,
  output logic                    out_walk_red,
  output logic [PHASE_CODE_W-1:0] out_phase_code,
  output logic                    out_pedestrian_active,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  cfg_t   cfg;
  stage_t stage;
  logic   take;

  ptls_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ptls_in_stage u_in_stage (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_tick         (in_tick),
    .in_button_press (in_button_press),
    .take            (take),
    .stage           (stage)
  );

  ptls_seq u_seq (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg                   (cfg),
    .stage                 (stage),
    .take                  (take),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_car_green         (out_car_green),
    .out_car_yellow        (out_car_yellow),
    .out_car_red           (out_car_red),
    .out_walk_green        (out_walk_green),
    .out_walk_yellow       (out_walk_yellow),
    .out_walk_red          (out_walk_red),
    .out_phase_code        (out_phase_code),
    .out_pedestrian_active (out_pedestrian_active)
  );

endmodule
